// File: hw/rtl/dccf_pkg.sv
// ----------------------------------------------------------------------------
// dccf_pkg
// Shared types and constants for the DDS channel command framer.
// ----------------------------------------------------------------------------
package dccf_pkg;

	typedef enum logic [1:0] {
		OP_FREQ  = 2'd0,
		OP_AMP   = 2'd1,
		OP_PHASE = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		REG_FREQ_SCALE  = 1'b0,
		REG_PHASE_SCALE = 1'b1
	} reg_idx_t;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned CH_W      = 2;
	localparam int unsigned VALUE_W   = 29;
	localparam int unsigned CFG_W     = 36;
	localparam int unsigned FSCALE_W  = 36;
	localparam int unsigned PSCALE_W  = 22;
	localparam int unsigned NBYTES    = 7;
	localparam int unsigned BIDX_W    = 3;

	localparam logic [FSCALE_W-1:0] FSCALE_RST = 36'd36893488147;
	localparam logic [PSCALE_W-1:0] PSCALE_RST = 22'd2982616;

	localparam logic [7:0]  ADDR_CSR    = 8'h00;
	localparam logic [7:0]  ADDR_FTW    = 8'h04;
	localparam logic [7:0]  ADDR_POW    = 8'h05;
	localparam logic [7:0]  ADDR_ACR    = 8'h06;
	localparam logic [7:0]  CH_SEL_BASE = 8'h10;
	localparam logic [15:0] AMP_ENABLE  = 16'h1000;
	localparam logic [9:0]  AMP_MAX     = 10'd1023;

	localparam logic [BIDX_W-1:0] LEN_FREQ  = 3'd7;
	localparam logic [BIDX_W-1:0] LEN_AMP   = 3'd6;
	localparam logic [BIDX_W-1:0] LEN_PHASE = 3'd5;

endpackage

// File: hw/rtl/dds_channel_command_framer.sv
// ----------------------------------------------------------------------------
// dds_channel_command_framer
// Turns frequency, amplitude and phase commands into serial-port bytes.
// ----------------------------------------------------------------------------
// Each accepted command produces two write frames for a four-channel DDS: a
// channel-select frame and a channel word frame, one byte per cycle on the
// byte channel while byte_ready is high. A frequency command gives 7 bytes,
// an amplitude command 6 and a phase command 5; command op 3 gives none. The
// byte output register sets the sustained rate at one byte per cycle while
// byte_ready is high, and the next byte list loads as the last byte is taken.
// A command passes the input register, the product register and the byte
// register before its first byte appears, and the next command is taken
// while the current one is still being sent.
module dds_channel_command_framer (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [dccf_pkg::CFG_W-1:0]    cfg_data,

	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [dccf_pkg::OP_W-1:0]     op,
	input  logic [dccf_pkg::CH_W-1:0]     channel,
	input  logic [dccf_pkg::VALUE_W-1:0]  value,

	output logic                          byte_valid,
	input  logic                          byte_ready,
	output logic [7:0]                    spi_byte,
	output logic                          frame_start,
	output logic                          frame_end,
	output logic                          update_pulse,
	output logic                          last
);
	import dccf_pkg::*;

	logic [FSCALE_W-1:0] fscale_q;
	logic [PSCALE_W-1:0] pscale_q;

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [VALUE_W-1:0]  val_s1;

	logic                valid_s2;
	logic [OP_W-1:0]     op_s2;
	logic [CH_W-1:0]     ch_s2;
	logic [31:0]         fhi_s2;
	logic [28:0]         flo_s2;
	logic [13:0]         phase_s2;
	logic [9:0]          amp_s2;

	logic                busy_q;
	logic [7:0]          byte_q [NBYTES];
	logic [BIDX_W-1:0]   idx_q;
	logic [BIDX_W-1:0]   len_q;
	logic                up_q;

	logic                out_take;
	logic                ser_free;
	logic                s2_take;
	logic                s1_take;
	logic                load_ser;
	logic                is_last;
	logic                op_ok;

	logic [60:0]         flo_prod;
	logic [32:0]         fhi_prod;
	logic [50:0]         ph_prod;
	logic [9:0]          amp_sat;

	logic [31:0]         tword;
	logic [15:0]         amp_word;
	logic [7:0]          ld_bytes [NBYTES];
	logic [BIDX_W-1:0]   ld_len;
	logic                ld_up;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fscale_q <= FSCALE_RST;
			pscale_q <= PSCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FREQ_SCALE:  fscale_q <= cfg_data[FSCALE_W-1:0];
				REG_PHASE_SCALE: pscale_q <= cfg_data[PSCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control between the stages.
	assign is_last  = (idx_q == len_q - BIDX_W'(1));
	assign out_take = busy_q && byte_ready;
	assign ser_free = !busy_q || (byte_ready && is_last);
	assign load_ser = valid_s2 && ser_free;
	assign s2_take  = !valid_s2 || ser_free;
	assign s1_take  = !valid_s1 || s2_take;
	assign cmd_ready = s1_take;
	assign op_ok = (op == OP_FREQ) || (op == OP_AMP) || (op == OP_PHASE);

	// Stage 1: command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= cmd_valid && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && cmd_valid) begin
			op_s1  <= op;
			ch_s1  <= channel;
			val_s1 <= value;
		end
	end

	// Stage 2: products and amplitude clamp.
	assign flo_prod = 61'(val_s1) * 61'(fscale_q[31:0]);
	assign fhi_prod = 33'(val_s1) * 33'(fscale_q[FSCALE_W-1:32]);
	assign ph_prod  = 51'(val_s1) * 51'(pscale_q);
	assign amp_sat  = (val_s1 > VALUE_W'(AMP_MAX)) ? AMP_MAX : val_s1[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && valid_s1) begin
			op_s2    <= op_s1;
			ch_s2    <= ch_s1;
			fhi_s2   <= fhi_prod[31:0];
			flo_s2   <= flo_prod[60:32];
			phase_s2 <= ph_prod[29:16];
			amp_s2   <= amp_sat;
		end
	end

	// Byte list for the command in stage 2.
	assign tword    = fhi_s2 + 32'(flo_s2);
	assign amp_word = AMP_ENABLE | 16'(amp_s2);

	always_comb begin
		ld_bytes[0] = ADDR_CSR;
		ld_bytes[1] = CH_SEL_BASE << ch_s2;
		ld_bytes[2] = ADDR_FTW;
		ld_bytes[3] = tword[31:24];
		ld_bytes[4] = tword[23:16];
		ld_bytes[5] = tword[15:8];
		ld_bytes[6] = tword[7:0];
		ld_len      = LEN_FREQ;
		ld_up       = 1'b1;
		case (op_s2)
			OP_FREQ: begin
			end
			OP_AMP: begin
				ld_bytes[2] = ADDR_ACR;
				ld_bytes[3] = 8'h00;
				ld_bytes[4] = amp_word[15:8];
				ld_bytes[5] = amp_word[7:0];
				ld_bytes[6] = 8'h00;
				ld_len      = LEN_AMP;
			end
			OP_PHASE: begin
				ld_bytes[2] = ADDR_POW;
				ld_bytes[3] = {2'b00, phase_s2[13:8]};
				ld_bytes[4] = phase_s2[7:0];
				ld_bytes[5] = 8'h00;
				ld_bytes[6] = 8'h00;
				ld_len      = LEN_PHASE;
				ld_up       = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Byte output register: a shift line that presents one byte per cycle while byte_ready is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			len_q  <= '0;
			up_q   <= 1'b0;
		end else if (load_ser) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			len_q  <= ld_len;
			up_q   <= ld_up;
		end else if (out_take) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + BIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_ser) begin
			for (int i = 0; i < NBYTES; i++) begin
				byte_q[i] <= ld_bytes[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < NBYTES - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
			end
		end
	end

	assign byte_valid   = busy_q;
	assign spi_byte     = byte_q[0];
	assign frame_start  = (idx_q == BIDX_W'(0)) || (idx_q == BIDX_W'(2));
	assign frame_end    = (idx_q == BIDX_W'(1)) || is_last;
	assign update_pulse = frame_end && up_q;
	assign last         = is_last;

	// The last byte of a command always closes a frame.
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && last |-> frame_end)
		else $error("last byte does not end a frame");

	// A taken byte that is not the last leaves another byte in place.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && !last |=> byte_valid)
		else $error("byte run broke off before its last byte");

	// A new byte list only loads once the current run is finished.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_ser |-> (!busy_q || (byte_ready && is_last)))
		else $error("byte list loaded over a running command");

	// Every command opens with the channel-select address.
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && idx_q == BIDX_W'(0) |-> spi_byte == ADDR_CSR && frame_start)
		else $error("command does not open with the channel-select frame");

endmodule
